### rtl/irrigation_window_timer_assert.svh
// ----------------------------------------------------------------------------
// irrigation window timer assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef IRRIGATION_WINDOW_TIMER_ASSERT_SVH
`define IRRIGATION_WINDOW_TIMER_ASSERT_SVH

`ifndef SYNTH

// property holds at every edge out of reset
`define IWT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("irrigation_window_timer: assertion failed");

// consequent holds in the cycle after the antecedent
`define IWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irrigation_window_timer: assertion failed");

`else

`define IWT_ASSERT(lbl, prop)
`define IWT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/iwt_pkg.sv
// ----------------------------------------------------------------------------
// iwt_pkg
// shared constants, codes and arithmetic helpers of the irrigation window timer
// ----------------------------------------------------------------------------
package iwt_pkg;

  // default prescale: ticks per clock second
  localparam int unsigned TICKS_PER_SECOND_DEF = 100;

  localparam int unsigned TRIM_W = 10;
  localparam int unsigned TIME_W = 6;
  localparam int unsigned SECS_W = 12;  // minutes*60+seconds, up to 3599

  localparam logic [TIME_W-1:0] LAST_UNIT = 6'd59;

  // event codes
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_ADJUST = 2'd3
  } cmd_e;

  // setup machine codes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CHOOSE = 2'd1;
  localparam logic [1:0] MODE_ADJUST = 2'd2;

  // setup targets
  localparam logic [1:0] TGT_CLOCK = 2'd0;
  localparam logic [1:0] TGT_START = 2'd1;
  localparam logic [1:0] TGT_END   = 2'd2;

  // reset values of the window
  localparam logic [TIME_W-1:0] START_MIN_RST = 6'd0;
  localparam logic [TIME_W-1:0] START_SEC_RST = 6'd10;
  localparam logic [TIME_W-1:0] END_MIN_RST   = 6'd1;
  localparam logic [TIME_W-1:0] END_SEC_RST   = 6'd2;

  // floor(raw*59/1023): quotient by shift, then one correction step
  function automatic logic [TIME_W-1:0] scale_trim(logic [TRIM_W-1:0] raw);
    logic [15:0]       prod;
    logic [TIME_W-1:0] q0;
    logic [16:0]       rem;
    prod = 16'(raw) * 16'd59;
    q0   = prod[15:10];
    rem  = 17'(prod) - 17'({q0, 10'b0}) + 17'(q0);
    if (rem >= 17'd1023) begin
      scale_trim = q0 + 6'd1;
    end else begin
      scale_trim = q0;
    end
  endfunction

  // minutes:seconds to seconds, times 60 as 64 - 4
  function automatic logic [SECS_W-1:0] to_secs(logic [TIME_W-1:0] mins,
                                                logic [TIME_W-1:0] secs);
    to_secs = 12'({mins, 6'b0}) - 12'({mins, 2'b0}) + 12'(secs);
  endfunction

endpackage

### rtl/irrigation_window_timer.sv
// ----------------------------------------------------------------------------
// irrigation_window_timer
// minutes:seconds clock with a start..end irrigation window and a button
// driven setup machine that loads scaled trimmer readings
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tuser: cmd; tdata: trim_minutes, trim_seconds
//  m_axis   | out | tdata: mode, selection, now, preview, irrigate, setup_lamp
//
//  one request per cycle is accepted into the input register while the result
//  is not stalled; the result register loads from it once the result slot is
//  free, and a valid result stays until it is taken
//  all state updates happen in the single step between the two registers
//  reset clears the clock, setup machine, prescaler and window to defaults
//  a stalled result holds the pipe; the input register still takes one
//  request while the result register waits
//
`include "irrigation_window_timer_assert.svh"

module irrigation_window_timer #(
  parameter int unsigned TICKS_PER_SECOND = iwt_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] trim_minutes, [19:10] trim_seconds, [23:20] zero
  input  logic [23:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] mode, [3:2] selection, [9:4] now_minutes, [15:10] now_seconds,
  // [21:16] preview_minutes, [27:22] preview_seconds, [28] irrigate,
  // [29] setup_lamp, [31:30] zero
  output logic [31:0] m_axis_tdata_o
);

  // prescaler width follows the tick count
  localparam int unsigned PRE_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(TICKS_PER_SECOND - 1);

  localparam int unsigned TW = iwt_pkg::TIME_W;

  // input register
  logic                         in_valid_q;
  iwt_pkg::cmd_e                cmd_q;
  logic [iwt_pkg::TRIM_W-1:0]   trim_min_q;
  logic [iwt_pkg::TRIM_W-1:0]   trim_sec_q;

  // block state
  logic [1:0]       mode_q, mode_d;
  logic [1:0]       sel_q, sel_d;
  logic [TW-1:0]    clk_min_q, clk_min_d;
  logic [TW-1:0]    clk_sec_q, clk_sec_d;
  logic [TW-1:0]    start_min_q, start_min_d;
  logic [TW-1:0]    start_sec_q, start_sec_d;
  logic [TW-1:0]    end_min_q, end_min_d;
  logic [TW-1:0]    end_sec_q, end_sec_d;
  logic [PRE_W-1:0] pre_q, pre_d;
  logic             lamp_q, lamp_d;

  // result register
  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic          advance;
  logic          in_setup;
  logic [TW-1:0] prev_min, prev_sec;
  logic          irrigate;
  logic [iwt_pkg::SECS_W-1:0] now_s, lo_s, hi_s;

  // the item in the input register moves on when the result slot frees up
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      cmd_q      <= iwt_pkg::cmd_e'(s_axis_tuser_i);
      trim_min_q <= s_axis_tdata_i[9:0];
      trim_sec_q <= s_axis_tdata_i[19:10];
    end
  end

  // scaled trimmer previews, shown in every mode
  assign prev_min = iwt_pkg::scale_trim(trim_min_q);
  assign prev_sec = iwt_pkg::scale_trim(trim_sec_q);

  // mode code 3 never occurs and counts as idle
  assign in_setup = (mode_q == iwt_pkg::MODE_CHOOSE) || (mode_q == iwt_pkg::MODE_ADJUST);

  // next state for the event in the input register
  always_comb begin
    mode_d      = mode_q;
    sel_d       = sel_q;
    clk_min_d   = clk_min_q;
    clk_sec_d   = clk_sec_q;
    start_min_d = start_min_q;
    start_sec_d = start_sec_q;
    end_min_d   = end_min_q;
    end_sec_d   = end_sec_q;
    pre_d       = pre_q;
    lamp_d      = lamp_q;
    case (cmd_q)
      iwt_pkg::CMD_TICK: begin
        if (pre_q >= PRE_LAST) begin
          pre_d = '0;
          // one second forward, wrap at 60 seconds and 60 minutes
          if (clk_sec_q >= iwt_pkg::LAST_UNIT) begin
            clk_sec_d = '0;
            if (clk_min_q >= iwt_pkg::LAST_UNIT) begin
              clk_min_d = '0;
            end else begin
              clk_min_d = clk_min_q + 6'd1;
            end
          end else begin
            clk_sec_d = clk_sec_q + 6'd1;
          end
        end else begin
          pre_d = pre_q + PRE_W'(1);
        end
      end
      iwt_pkg::CMD_SELECT: begin
        if (!in_setup) begin
          mode_d = iwt_pkg::MODE_CHOOSE;
          lamp_d = 1'b1;
        end else if (mode_q == iwt_pkg::MODE_CHOOSE) begin
          // clock -> start -> end -> clock
          sel_d = (sel_q >= iwt_pkg::TGT_END) ? iwt_pkg::TGT_CLOCK : sel_q + 2'd1;
        end else begin
          // commit the previews to the chosen target
          case (sel_q)
            iwt_pkg::TGT_CLOCK: begin
              clk_min_d = prev_min;
              clk_sec_d = prev_sec;
            end
            iwt_pkg::TGT_START: begin
              start_min_d = prev_min;
              start_sec_d = prev_sec;
            end
            iwt_pkg::TGT_END: begin
              end_min_d = prev_min;
              end_sec_d = prev_sec;
            end
            default: begin
            end
          endcase
          mode_d = iwt_pkg::MODE_IDLE;
          lamp_d = 1'b0;
        end
      end
      iwt_pkg::CMD_CANCEL: begin
        if (in_setup) begin
          mode_d = iwt_pkg::MODE_IDLE;
          lamp_d = 1'b0;
        end
      end
      iwt_pkg::CMD_ADJUST: begin
        if (mode_q == iwt_pkg::MODE_CHOOSE) begin
          mode_d = iwt_pkg::MODE_ADJUST;
        end
      end
      default: begin
      end
    endcase
  end

  // window check on the updated state, inclusive at both ends
  assign now_s    = iwt_pkg::to_secs(clk_min_d, clk_sec_d);
  assign lo_s     = iwt_pkg::to_secs(start_min_d, start_sec_d);
  assign hi_s     = iwt_pkg::to_secs(end_min_d, end_sec_d);
  assign irrigate = (now_s >= lo_s) && (now_s <= hi_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= iwt_pkg::MODE_IDLE;
      sel_q       <= iwt_pkg::TGT_CLOCK;
      clk_min_q   <= '0;
      clk_sec_q   <= '0;
      start_min_q <= iwt_pkg::START_MIN_RST;
      start_sec_q <= iwt_pkg::START_SEC_RST;
      end_min_q   <= iwt_pkg::END_MIN_RST;
      end_sec_q   <= iwt_pkg::END_SEC_RST;
      pre_q       <= '0;
      lamp_q      <= 1'b0;
    end else if (advance) begin
      mode_q      <= mode_d;
      sel_q       <= sel_d;
      clk_min_q   <= clk_min_d;
      clk_sec_q   <= clk_sec_d;
      start_min_q <= start_min_d;
      start_sec_q <= start_sec_d;
      end_min_q   <= end_min_d;
      end_sec_q   <= end_sec_d;
      pre_q       <= pre_d;
      lamp_q      <= lamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, lamp_d, irrigate, prev_sec, prev_min,
                     clk_sec_d, clk_min_d, sel_d, mode_d};
    end
  end

  // lamp tracks the setup modes
  `IWT_ASSERT(a_lamp_mode, lamp_q == in_setup)
  // prescaler never passes its last count
  `IWT_ASSERT(a_pre_range, pre_q <= PRE_LAST)
  // clock stays a valid minutes:seconds value
  `IWT_ASSERT(a_clock_range, (clk_sec_q <= iwt_pkg::LAST_UNIT) && (clk_min_q <= iwt_pkg::LAST_UNIT))
  // a request moving on always leaves a result behind
  `IWT_ASSERT_NEXT(a_advance_out, advance, out_valid_q)

endmodule

### bench/irrigation_window_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrigation_window_timer_tb
// drives tick and button requests with trimmer readings into the timer and
// checks every display result against a cycle-free model of the clock, the
// window and the setup machine or a table entry; directed table first, then random sequences
// ----------------------------------------------------------------------------
module irrigation_window_timer_tb;
  import iwt_pkg::*;

  localparam int unsigned TICKS        = TICKS_PER_SECOND_DEF;
  localparam int          NUM_DIRECTED = 25;
  localparam int          NUM_RANDOM   = 350;
  localparam int          STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int          DRAIN_CYCLES = 8;     // extra wait once no result is expected

  // display result, laid out exactly as m_axis_tdata_o (msb first)
  typedef struct packed {
    logic [1:0]        reserved;
    logic              lamp;
    logic              irrigate;
    logic [TIME_W-1:0] pv_sec;
    logic [TIME_W-1:0] pv_min;
    logic [TIME_W-1:0] now_sec;
    logic [TIME_W-1:0] now_min;
    logic [1:0]        sel;
    logic [1:0]        mode;
  } display_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    cmd_e              cmd;
    logic [TRIM_W-1:0] trim_min;
    logic [TRIM_W-1:0] trim_sec;
    logic              typed;
    display_t          want;
  } stim_row_t;

  function automatic display_t shown(logic [1:0] mode_v, logic [1:0] sel_v,
                                     logic [5:0] nm, logic [5:0] ns,
                                     logic [5:0] pm, logic [5:0] ps,
                                     logic irr, logic lamp_v);
    display_t d;
    d          = '0;
    d.mode     = mode_v;
    d.sel      = sel_v;
    d.now_min  = nm;
    d.now_sec  = ns;
    d.pv_min   = pm;
    d.pv_sec   = ps;
    d.irrigate = irr;
    d.lamp     = lamp_v;
    return d;
  endfunction

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;   // [9:0] trim_minutes, [19:10] trim_seconds, [23:20] zero
  logic [1:0]  s_user = '0;   // [1:0] cmd
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;        // display_t layout

  display_t display_q[$];     // expected display results, oldest first
  int       mismatch_count = 0;
  int       sent = 0;
  int       cyc = 0;
  int       stall_cycles = 0;

  // predicted block state, at reset values
  logic [1:0]  p_mode   = MODE_IDLE;
  logic [1:0]  p_target = TGT_CLOCK;
  logic        p_lamp   = 1'b0;
  int unsigned wall_min = 0;
  int unsigned wall_sec = 0;
  int unsigned win_start_min = START_MIN_RST;
  int unsigned win_start_sec = START_SEC_RST;
  int unsigned win_end_min   = END_MIN_RST;
  int unsigned win_end_sec   = END_SEC_RST;
  int unsigned prescale      = 0;

  // directed table: reset view, trimmer extremes, every button in idle, all but tick
  // in both setup modes, a committed start later than the end, and a one-second window hit exactly
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{CMD_TICK,   10'd0,    10'd1023, 1'b1,
      shown(MODE_IDLE, TGT_CLOCK, 6'd0, 6'd0, 6'd0, 6'd59, 1'b0, 1'b0)},
    // cancel in idle does nothing
    '{CMD_CANCEL, 10'd1023, 10'd0,    1'b1,
      shown(MODE_IDLE, TGT_CLOCK, 6'd0, 6'd0, 6'd59, 6'd0, 1'b0, 1'b0)},
    // adjust in idle does nothing
    '{CMD_ADJUST, 10'd0,    10'd0,    1'b1,
      shown(MODE_IDLE, TGT_CLOCK, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 1'b0)},
    '{CMD_SELECT, 10'd512,  10'd511,  1'b0, display_t'(0)},
    '{CMD_CANCEL, 10'd700,  10'd300,  1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd17,   10'd18,   1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd341,  10'd682,  1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd1022, 10'd1,    1'b0, display_t'(0)},
    // target wraps from end back to clock
    '{CMD_SELECT, 10'd1,    10'd1022, 1'b0, display_t'(0)},
    '{CMD_ADJUST, 10'd600,  10'd400,  1'b0, display_t'(0)},
    // adjust while adjusting is ignored
    '{CMD_ADJUST, 10'd100,  10'd900,  1'b0, display_t'(0)},
    // commit the clock to 59:59
    '{CMD_SELECT, 10'd1023, 10'd1023, 1'b1,
      shown(MODE_IDLE, TGT_CLOCK, 6'd59, 6'd59, 6'd59, 6'd59, 1'b0, 1'b0)},
    '{CMD_SELECT, 10'd256,  10'd768,  1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd768,  10'd256,  1'b0, display_t'(0)},
    '{CMD_ADJUST, 10'd0,    10'd0,    1'b0, display_t'(0)},
    // cancel while adjusting stores nothing
    '{CMD_CANCEL, 10'd0,    10'd0,    1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd33,   10'd990,  1'b0, display_t'(0)},
    '{CMD_ADJUST, 10'd990,  10'd33,   1'b0, display_t'(0)},
    // start 59:59 lies after end 1:02, window empty
    '{CMD_SELECT, 10'd1023, 10'd1023, 1'b1,
      shown(MODE_IDLE, TGT_START, 6'd59, 6'd59, 6'd59, 6'd59, 1'b0, 1'b0)},
    '{CMD_SELECT, 10'd5,    10'd6,    1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd7,    10'd8,    1'b0, display_t'(0)},
    '{CMD_ADJUST, 10'd9,    10'd10,   1'b0, display_t'(0)},
    // end 59:59 too, clock sits on both inclusive bounds
    '{CMD_SELECT, 10'd1023, 10'd1023, 1'b1,
      shown(MODE_IDLE, TGT_END, 6'd59, 6'd59, 6'd59, 6'd59, 1'b1, 1'b0)},
    '{CMD_TICK,   10'd1,    10'd1,    1'b0, display_t'(0)},
    '{CMD_SELECT, 10'd341,  10'd682,  1'b0, display_t'(0)}
  };

  irrigation_window_timer #(
    .TICKS_PER_SECOND(TICKS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // a stretch with no idling on either side, well inside the shortest run
  function automatic logic quiet();
    return (cyc >= 150) && (cyc < 350);
  endfunction

  // updates the predicted state for one request and returns the display
  function automatic display_t predict_display(cmd_e cmd, logic [TRIM_W-1:0] tm,
                                               logic [TRIM_W-1:0] ts);
    display_t    d;
    int unsigned pm, ps, now_s, lo_s, hi_s;
    logic        in_setup;
    pm       = (int'(tm) * 59) / 1023;
    ps       = (int'(ts) * 59) / 1023;
    in_setup = (p_mode == MODE_CHOOSE) || (p_mode == MODE_ADJUST);
    case (cmd)
      CMD_TICK: begin
        if (prescale + 1 >= TICKS) begin
          prescale = 0;
          wall_sec++;
          if (wall_sec >= 60) begin
            wall_sec = 0;
            wall_min = (wall_min >= 59) ? 0 : wall_min + 1;
          end
        end else begin
          prescale++;
        end
      end
      CMD_SELECT: begin
        if (!in_setup) begin
          p_mode = MODE_CHOOSE;
          p_lamp = 1'b1;
        end else if (p_mode == MODE_CHOOSE) begin
          p_target = (p_target >= TGT_END) ? TGT_CLOCK : 2'(p_target + 1);
        end else begin
          // commit the scaled trimmer values to the chosen target
          case (p_target)
            TGT_CLOCK: begin
              wall_min = pm;
              wall_sec = ps;
            end
            TGT_START: begin
              win_start_min = pm;
              win_start_sec = ps;
            end
            TGT_END: begin
              win_end_min = pm;
              win_end_sec = ps;
            end
            default: ;
          endcase
          p_mode = MODE_IDLE;
          p_lamp = 1'b0;
        end
      end
      CMD_CANCEL: begin
        if (in_setup) begin
          p_mode = MODE_IDLE;
          p_lamp = 1'b0;
        end
      end
      default: begin
        if (p_mode == MODE_CHOOSE) p_mode = MODE_ADJUST;
      end
    endcase
    now_s = wall_min * 60 + wall_sec;
    lo_s  = win_start_min * 60 + win_start_sec;
    hi_s  = win_end_min * 60 + win_end_sec;
    d = shown(p_mode, p_target, 6'(wall_min), 6'(wall_sec), 6'(pm), 6'(ps),
              (now_s >= lo_s) && (now_s <= hi_s), p_lamp);
    return d;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(cmd_e cmd, logic [TRIM_W-1:0] tm, logic [TRIM_W-1:0] ts,
                              logic typed, display_t want);
    display_t next_view;
    while (!quiet() && ($urandom_range(0, 99) < 15)) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {4'b0, ts, tm};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    next_view = predict_display(cmd, tm, ts);
    display_q.push_back(typed ? want : next_view);
    sent++;
    @(negedge clk);
  endtask

  // trimmer readings leaning toward the ends of the scale
  function automatic logic [TRIM_W-1:0] rand_trim();
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'($urandom_range(1000, 1023));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic press(cmd_e cmd);
    send_request(cmd, rand_trim(), rand_trim(), 1'b0, display_t'(0));
  endtask

  // well-formed setup pass from idle, sometimes broken off by a cancel;
  // with wrap_clock the clock is loaded close to 59 seconds, often at minute 59, and left ticking
  task automatic setup_pass(logic wrap_clock);
    if (p_mode != MODE_IDLE) press(CMD_CANCEL);
    press(CMD_SELECT);
    if (wrap_clock) begin
      while (p_target != TGT_CLOCK) press(CMD_SELECT);
      press(CMD_ADJUST);
      send_request(CMD_SELECT, $urandom_range(0, 1) ? 10'd1023 : rand_trim(),
                   10'($urandom_range(1000, 1023)), 1'b0, display_t'(0));
      repeat ($urandom_range(100, 250)) press(CMD_TICK);
    end else begin
      repeat ($urandom_range(0, 4)) press(CMD_SELECT);
      if ($urandom_range(0, 7) == 0) begin
        press(CMD_CANCEL);
      end else begin
        press(CMD_ADJUST);
        if ($urandom_range(0, 5) == 0) press(CMD_ADJUST);
        press(($urandom_range(0, 5) == 0) ? CMD_CANCEL : CMD_SELECT);
      end
    end
  endtask

  // result receiver, stalls at random outside the quiet stretch
  always @(negedge clk) begin
    m_ready <= quiet() || ($urandom_range(0, 99) >= 15);
  end

  // result checker
  always @(posedge clk) begin
    display_t got, want;
    if (rst_n && m_valid && m_ready) begin
      got = m_data;
      if (display_q.size() == 0) begin
        $error("result with nothing expected: %h", m_data);
        mismatch_count++;
      end else begin
        want = display_q.pop_front();
        if (got.mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, got.mode);
          mismatch_count++;
        end
        if (got.sel !== want.sel) begin
          $error("selection: expected %0d, got %0d", want.sel, got.sel);
          mismatch_count++;
        end
        if (got.now_min !== want.now_min) begin
          $error("now_minutes: expected %0d, got %0d", want.now_min, got.now_min);
          mismatch_count++;
        end
        if (got.now_sec !== want.now_sec) begin
          $error("now_seconds: expected %0d, got %0d", want.now_sec, got.now_sec);
          mismatch_count++;
        end
        if (got.pv_min !== want.pv_min) begin
          $error("preview_minutes: expected %0d, got %0d", want.pv_min, got.pv_min);
          mismatch_count++;
        end
        if (got.pv_sec !== want.pv_sec) begin
          $error("preview_seconds: expected %0d, got %0d", want.pv_sec, got.pv_sec);
          mismatch_count++;
        end
        if (got.irrigate !== want.irrigate) begin
          $error("irrigate: expected %0d, got %0d", want.irrigate, got.irrigate);
          mismatch_count++;
        end
        if (got.lamp !== want.lamp) begin
          $error("setup_lamp: expected %0d, got %0d", want.lamp, got.lamp);
          mismatch_count++;
        end
        if (got.reserved !== want.reserved) begin
          $error("padding: expected %0d, got %0d", want.reserved, got.reserved);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int pick;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].trim_min,
                   directed_rows[i].trim_sec, directed_rows[i].typed,
                   directed_rows[i].want);
    end

    // mostly well-formed setup passes and tick bursts, some loose requests
    while (sent < NUM_DIRECTED + NUM_RANDOM) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        setup_pass(1'b0);
      end else if (pick == 4) begin
        setup_pass(1'b1);
      end else if (pick < 7) begin
        repeat ($urandom_range(1, 120)) press(CMD_TICK);
      end else begin
        repeat ($urandom_range(1, 4)) press(cmd_e'($urandom_range(0, 3)));
      end
    end
    s_valid <= 1'b0;

    while (display_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### irrigation_window_timer.f
+incdir+rtl
rtl/iwt_pkg.sv
rtl/irrigation_window_timer.sv
bench/irrigation_window_timer_tb.sv
